@@ design/msfd_pkg.sv @@
// ----------------------------------------------------------------------------
// msfd_pkg: shared types and constants of the magic sync frame deframer
// Header window layout, configuration and result records, kind and register
// codes, and the window shift helper.
// ----------------------------------------------------------------------------
package msfd_pkg;

    localparam int HDR_BYTES     = 8;
    localparam int COUNT_WIDTH_D = 32;
    localparam int TOTAL_WIDTH   = 32;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;

    typedef logic [7:0]                  byte_t;
    typedef byte_t [HDR_BYTES-1:0]       win_t;
    typedef logic [$clog2(HDR_BYTES)-1:0] pos_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    localparam logic [1:0] MODE_HOST_BOUND = 2'd0;
    localparam logic [1:0] MODE_TO_MODULE  = 2'd1;

    localparam logic [1:0] REG_EXPECT_MODE = 2'd0;
    localparam logic [1:0] REG_MAGIC_FROM  = 2'd1;
    localparam logic [1:0] REG_MAGIC_TO    = 2'd2;
    localparam logic [1:0] REG_MAX_LEN     = 2'd3;

    localparam logic [1:0]  EXPECT_MODE_RST = 2'd2;
    localparam logic [15:0] MAX_LEN_RST     = 16'd2048;

    typedef struct packed {
        logic [1:0]  expect_mode;
        logic [15:0] magic_from;
        logic [15:0] magic_to;
        logic [15:0] max_len;
    } cfg_t;

    // Hunting and payload state carried from beat to beat
    typedef struct packed {
        win_t        win;
        pos_t        fill;
        logic [15:0] remaining;
        logic        in_payload;
    } hunt_t;

    // Counter increments from one beat
    typedef struct packed {
        logic [2:0] garbage_inc;
        logic       bad_inc;
    } cnt_ctl_t;

    typedef struct packed {
        kind_t       kind;
        logic        host_bound;
        logic [7:0]  frame_type;
        logic [3:0]  if_index;
        logic [3:0]  frame_flags;
        logic [15:0] frame_length;
        logic [15:0] frame_cookie;
        logic [7:0]  payload_byte;
        logic        last;
    } frame_res_t;

    typedef struct packed {
        frame_res_t             frame;
        logic [TOTAL_WIDTH-1:0] garbage_total;
        logic [TOTAL_WIDTH-1:0] bad_length_total;
    } res_t;

    // Drop the first s bytes of the window; bytes past the fill are don't care
    function automatic win_t win_shift(win_t w, pos_t s);
        win_t r;
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            r[i] = w[pos_t'(i) + s];
        end
        return r;
    endfunction

endpackage

@@ design/msfd_step.sv @@
// ----------------------------------------------------------------------------
// msfd_step: one-beat hunting and payload logic
// Appends the new byte to the header window, searches for an allowed magic,
// checks the length and produces the next state, the result and the counter
// increments in a single combinational pass.
// ----------------------------------------------------------------------------
module msfd_step (
    input  msfd_pkg::hunt_t      st,
    input  msfd_pkg::cfg_t       cfg,
    input  logic [7:0]           data_byte,
    output msfd_pkg::hunt_t      st_next,
    output msfd_pkg::frame_res_t res,
    output msfd_pkg::cnt_ctl_t   ctl
);
    import msfd_pkg::*;

    win_t                 cur;
    logic [HDR_BYTES-2:0] match;
    logic [3:0]           n;
    logic                 found;
    pos_t                 p;
    logic                 found2;
    pos_t                 q;
    logic [15:0]          len;
    logic                 len_ok;
    logic [15:0]          rem_dec;
    logic [15:0]          rem_hdr;

    function automatic logic magic_ok(cfg_t c, logic [15:0] w);
        logic a;
        logic b;
        a = (w == c.magic_from);
        b = (w == c.magic_to);
        case (c.expect_mode)
            MODE_HOST_BOUND: return a;
            MODE_TO_MODULE:  return b;
            default:         return a || b;
        endcase
    endfunction

    always_comb
    begin
        cur           = st.win;
        cur[st.fill]  = data_byte;
        n             = {1'b0, st.fill} + 4'd1;

        for (int i = 0; i < HDR_BYTES - 1; i++)
        begin
            match[i] = magic_ok(cfg, {cur[i+1], cur[i]}) && (4'(i + 1) < n);
        end

        // first magic from the front, then the rescan that skips byte 0
        found  = 1'b0;
        p      = '0;
        found2 = 1'b0;
        q      = '0;
        for (int i = HDR_BYTES - 2; i >= 0; i--)
        begin
            if (match[i])
            begin
                found = 1'b1;
                p     = pos_t'(i);
            end
        end
        for (int i = HDR_BYTES - 2; i >= 1; i--)
        begin
            if (match[i])
            begin
                found2 = 1'b1;
                q      = pos_t'(i);
            end
        end

        len     = {cur[5], cur[4]};
        len_ok  = (len >= 16'(HDR_BYTES)) && (len <= cfg.max_len);
        rem_dec = st.remaining - 16'd1;
        rem_hdr = len - 16'(HDR_BYTES);

        st_next = st;
        res     = '0;
        ctl     = '0;

        if (st.in_payload)
        begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = data_byte;
            st_next.remaining = rem_dec;
            if (rem_dec == 16'd0)
            begin
                st_next.in_payload = 1'b0;
                res.last           = 1'b1;
            end
        end
        else if (!found)
        begin
            // keep only the newest byte, it may start a magic
            ctl.garbage_inc = st.fill;
            st_next.win[0]  = data_byte;
            st_next.fill    = pos_t'(1);
        end
        else if (!((st.fill == pos_t'(HDR_BYTES - 1)) && (p == '0)))
        begin
            ctl.garbage_inc = p;
            st_next.win     = win_shift(cur, p);
            st_next.fill    = pos_t'(n - {1'b0, p});
        end
        else if (len_ok)
        begin
            res.kind           = KIND_HEADER;
            res.host_bound     = ({cur[1], cur[0]} == cfg.magic_from);
            res.frame_type     = cur[2];
            res.if_index       = cur[3][7:4];
            res.frame_flags    = cur[3][3:0];
            res.frame_length   = len;
            res.frame_cookie   = {cur[7], cur[6]};
            res.last           = (rem_hdr == 16'd0);
            st_next.fill       = '0;
            st_next.remaining  = rem_hdr;
            st_next.in_payload = (rem_hdr != 16'd0);
        end
        else
        begin
            ctl.bad_inc = 1'b1;
            if (found2)
            begin
                ctl.garbage_inc = q - pos_t'(1);
                st_next.win     = win_shift(cur, q);
                st_next.fill    = pos_t'(4'(HDR_BYTES) - {1'b0, q});
            end
            else
            begin
                ctl.garbage_inc = 3'(HDR_BYTES - 2);
                st_next.win[0]  = data_byte;
                st_next.fill    = pos_t'(1);
            end
        end
    end

endmodule

@@ design/magic_sync_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// magic_sync_frame_deframer: byte-stream deframer with magic sync and length
// Finds an allowed little-endian magic word, validates the 8-byte header and
// passes the payload through, with garbage and bad-length counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one raw stream byte per beat on data_byte (in_valid and
//   in_ready). Output channel: exactly one result beat per input beat
//   (out_valid and out_ready): kind none, frame header or payload byte, with
//   the running garbage and bad-length totals on every beat.
//   A beat's result is registered in the output register, or in the skid
//   register while the output stalls. Throughput: one byte per cycle while
//   in_ready is high; the header scan, length check and counter adds all fit
//   in the single pass from the state registers to the result register.
//   The output side has a result register and a skid register, so input is
//   still taken while one finished result waits; in_ready drops only when
//   both are full, and rises again the cycle after the receiver takes a beat.
//   Reset: hunting with an empty window, counters zero, expect_mode 2,
//   both magics 0, max_frame_length 2048; output buffer empty.
//   Configuration: APB registers at 0x0 expect_mode, 0x4 module-to-host
//   magic, 0x8 host-to-module magic, 0xC max_frame_length. Write them only
//   while idle; a frame in payload keeps the length it already decoded.
// ----------------------------------------------------------------------------
module magic_sync_frame_deframer #(
    parameter int COUNT_WIDTH = msfd_pkg::COUNT_WIDTH_D
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msfd_pkg::APB_AW-1:0]   paddr,
    input  logic [msfd_pkg::APB_DW-1:0]   pwdata,
    output logic [msfd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // byte input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    // results
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic                          host_bound,
    output logic [7:0]                    frame_type,
    output logic [3:0]                    if_index,
    output logic [3:0]                    frame_flags,
    output logic [15:0]                   frame_length,
    output logic [15:0]                   frame_cookie,
    output logic [7:0]                    payload_byte,
    output logic                          last,
    output logic [msfd_pkg::TOTAL_WIDTH-1:0] garbage_total,
    output logic [msfd_pkg::TOTAL_WIDTH-1:0] bad_length_total
);
    import msfd_pkg::*;

    cfg_t                   cfg_reg;
    hunt_t                  st_reg;
    hunt_t                  st_next;
    frame_res_t             frame_res;
    cnt_ctl_t               ctl;
    logic [COUNT_WIDTH-1:0] garbage_reg;
    logic [COUNT_WIDTH-1:0] garbage_next;
    logic [COUNT_WIDTH-1:0] bad_reg;
    logic [COUNT_WIDTH-1:0] bad_next;
    logic [TOTAL_WIDTH-1:0] garbage_tot;
    logic [TOTAL_WIDTH-1:0] bad_tot;
    res_t                   res_new;
    res_t                   out_reg;
    res_t                   skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic                   push;
    logic                   pop;
    logic                   cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expect_mode <= EXPECT_MODE_RST;
            cfg_reg.magic_from  <= '0;
            cfg_reg.magic_to    <= '0;
            cfg_reg.max_len     <= MAX_LEN_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_EXPECT_MODE: cfg_reg.expect_mode <= pwdata[1:0];
                REG_MAGIC_FROM:  cfg_reg.magic_from  <= pwdata[15:0];
                REG_MAGIC_TO:    cfg_reg.magic_to    <= pwdata[15:0];
                REG_MAX_LEN:     cfg_reg.max_len     <= pwdata[15:0];
                default:         cfg_reg.expect_mode <= cfg_reg.expect_mode;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_EXPECT_MODE: prdata = {30'd0, cfg_reg.expect_mode};
            REG_MAGIC_FROM:  prdata = {16'd0, cfg_reg.magic_from};
            REG_MAGIC_TO:    prdata = {16'd0, cfg_reg.magic_to};
            REG_MAX_LEN:     prdata = {16'd0, cfg_reg.max_len};
            default:         prdata = '0;
        endcase
    end

    // ---------------- per-beat hunting logic ----------------
    msfd_step u_step (
        .st        (st_reg),
        .cfg       (cfg_reg),
        .data_byte (data_byte),
        .st_next   (st_next),
        .res       (frame_res),
        .ctl       (ctl)
    );

    // Counters wrap at COUNT_WIDTH; the reported totals are the low 32 bits
    assign garbage_next = garbage_reg + COUNT_WIDTH'(ctl.garbage_inc);
    assign bad_next     = bad_reg + COUNT_WIDTH'(ctl.bad_inc);

    generate
        if (COUNT_WIDTH >= TOTAL_WIDTH)
        begin : g_tot_trunc
            assign garbage_tot = garbage_next[TOTAL_WIDTH-1:0];
            assign bad_tot     = bad_next[TOTAL_WIDTH-1:0];
        end
        else
        begin : g_tot_ext
            assign garbage_tot = {{(TOTAL_WIDTH - COUNT_WIDTH){1'b0}}, garbage_next};
            assign bad_tot     = {{(TOTAL_WIDTH - COUNT_WIDTH){1'b0}}, bad_next};
        end
    endgenerate

    always_comb
    begin
        res_new.frame            = frame_res;
        res_new.garbage_total    = garbage_tot;
        res_new.bad_length_total = bad_tot;
    end

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    // Advance state and counters on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '0;
            garbage_reg <= '0;
            bad_reg     <= '0;
        end
        else if (push)
        begin
            st_reg      <= st_next;
            garbage_reg <= garbage_next;
            bad_reg     <= bad_next;
        end
    end

    // ---------------- output register and skid stage ----------------
    // Hold a result in the skid register while the receiver stalls the
    // output register; refill the output from the skid first on a pop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= res_new;
            end
        end
        else if (push)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = out_reg.frame.kind;
    assign host_bound       = out_reg.frame.host_bound;
    assign frame_type       = out_reg.frame.frame_type;
    assign if_index         = out_reg.frame.if_index;
    assign frame_flags      = out_reg.frame.frame_flags;
    assign frame_length     = out_reg.frame.frame_length;
    assign frame_cookie     = out_reg.frame.frame_cookie;
    assign payload_byte     = out_reg.frame.payload_byte;
    assign last             = out_reg.frame.last;
    assign garbage_total    = out_reg.garbage_total;
    assign bad_length_total = out_reg.bad_length_total;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the magic sync frame deframer
// Streams raw bytes through the deframer and predicts every result beat in
// the testbench: magic hunting, header window rescans, bad-length rejects,
// payload pass-through and the garbage and bad-length totals. Both channels
// idle and stall at random, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import msfd_pkg::*;

    // Cycles without any beat before the run is declared hung. The slowest
    // correct gap is a receiver stall (where one pattern's trailing stall runs
    // into the next one's) or a register update; the limit is many times either.
    localparam int STALL_LIMIT = 2000;

    // Target bytes per random phase
    localparam int PHASE_BYTES = 106;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [APB_AW-1:0]    paddr     = '0;
    logic [APB_DW-1:0]    pwdata    = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte = 8'h00;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           kind;
    logic                 host_bound;
    logic [7:0]           frame_type;
    logic [3:0]           if_index;
    logic [3:0]           frame_flags;
    logic [15:0]          frame_length;
    logic [15:0]          frame_cookie;
    logic [7:0]           payload_byte;
    logic                 last;
    logic [TOTAL_WIDTH-1:0] garbage_total;
    logic [TOTAL_WIDTH-1:0] bad_length_total;

    magic_sync_frame_deframer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .host_bound       (host_bound),
        .frame_type       (frame_type),
        .if_index         (if_index),
        .frame_flags      (frame_flags),
        .frame_length     (frame_length),
        .frame_cookie     (frame_cookie),
        .payload_byte     (payload_byte),
        .last             (last),
        .garbage_total    (garbage_total),
        .bad_length_total (bad_length_total)
    );

    // ------------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------------
    byte_t       pending_bytes[$];     // raw stream not yet handed to the driver
    res_t        expected_results[$];  // predicted result beats, oldest first
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    bit          in_fire        = 1'b0; // input beat taken at the last rising edge

    // Shadow of the configuration registers
    logic [1:0]  cfg_mode   = EXPECT_MODE_RST;
    logic [15:0] magic_mod  = 16'h0000;
    logic [15:0] magic_host = 16'h0000;
    logic [15:0] max_len    = MAX_LEN_RST;

    // Shadow of the hunting and payload state
    byte_t       hdr_win[HDR_BYTES];
    int unsigned win_fill   = 0;
    logic [15:0] pay_left   = 16'h0000;
    bit          in_frame   = 1'b0;
    logic [31:0] garbage_cnt = '0;
    logic [31:0] badlen_cnt  = '0;

    // ------------------------------------------------------------------------
    // Deframer prediction
    // ------------------------------------------------------------------------
    function automatic bit magic_accepted(input logic [15:0] w);
        bit hit_mod;
        bit hit_host;
        hit_mod  = (w == magic_mod);
        hit_host = (w == magic_host);
        case (cfg_mode)
            MODE_HOST_BOUND: return hit_mod;
            MODE_TO_MODULE:  return hit_host;
            default:         return hit_mod || hit_host; // mode 3 acts as either
        endcase
    endfunction

    function automatic logic [15:0] win_word(input int unsigned i);
        return {hdr_win[(i + 1) % HDR_BYTES], hdr_win[i % HDR_BYTES]};
    endfunction

    function automatic void drop_front(input int unsigned n);
        if (n >= win_fill)
        begin
            win_fill = 0;
        end
        else
        begin
            for (int unsigned i = 0; i + n < win_fill; i++)
                hdr_win[i] = hdr_win[i + n];
            win_fill -= n;
        end
    endfunction

    // Advance the shadow state by one stream byte and queue its result beat
    function automatic void deframe_byte(input byte_t b);
        res_t        r;
        int unsigned pos;
        bit          found;
        logic [15:0] len;
        r = '0;
        if (in_frame)
        begin
            r.frame.kind         = KIND_PAYLOAD;
            r.frame.payload_byte = b;
            pay_left             = pay_left - 16'd1;
            if (pay_left == 16'd0)
            begin
                in_frame     = 1'b0;
                r.frame.last = 1'b1;
            end
        end
        else
        begin
            if (win_fill >= HDR_BYTES)
                drop_front(1);
            hdr_win[win_fill] = b;
            win_fill++;
            while (1'b1)
            begin
                pos   = 0;
                found = 1'b0;
                while (pos + 1 < win_fill)
                begin
                    if (magic_accepted(win_word(pos)))
                    begin
                        found = 1'b1;
                        break;
                    end
                    pos++;
                end
                // No magic: keep only the newest byte, it may start one
                if (!found)
                begin
                    if (win_fill > 1)
                    begin
                        garbage_cnt += win_fill - 1;
                        drop_front(win_fill - 1);
                    end
                    break;
                end
                if (pos > 0)
                begin
                    garbage_cnt += pos;
                    drop_front(pos);
                end
                if (win_fill < HDR_BYTES)
                    break;
                // Full header: reject a bad length and rescan from byte 1
                len = win_word(4);
                if (len < HDR_BYTES || len > max_len)
                begin
                    badlen_cnt++;
                    drop_front(1);
                    continue;
                end
                r.frame.kind         = KIND_HEADER;
                r.frame.host_bound   = (win_word(0) == magic_mod);
                r.frame.frame_type   = hdr_win[2];
                r.frame.if_index     = hdr_win[3][7:4];
                r.frame.frame_flags  = hdr_win[3][3:0];
                r.frame.frame_length = len;
                r.frame.frame_cookie = win_word(6);
                pay_left             = len - 16'(HDR_BYTES);
                in_frame             = (pay_left != 16'd0);
                r.frame.last         = !in_frame;
                win_fill             = 0;
                break;
            end
        end
        r.garbage_total    = garbage_cnt;
        r.bad_length_total = badlen_cnt;
        expected_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Stream construction
    // ------------------------------------------------------------------------
    function automatic void push_frame(input logic [15:0] magic, input logic [7:0] ftype,
                                       input logic [7:0] tag, input logic [15:0] len,
                                       input logic [15:0] cookie, input int unsigned body);
        pending_bytes.push_back(magic[7:0]);
        pending_bytes.push_back(magic[15:8]);
        pending_bytes.push_back(ftype);
        pending_bytes.push_back(tag);
        pending_bytes.push_back(len[7:0]);
        pending_bytes.push_back(len[15:8]);
        pending_bytes.push_back(cookie[7:0]);
        pending_bytes.push_back(cookie[15:8]);
        repeat (body) pending_bytes.push_back(8'($urandom));
    endfunction

    // Mostly well-formed frames for the current settings, plus frames with a
    // bad length or the other magic (random in modes 2 and 3), noise and cut-off headers.
    function automatic void build_phase(input int unsigned target);
        logic [15:0] good_magic;
        logic [15:0] odd_magic;
        logic [15:0] len;
        int unsigned pick;
        int unsigned body;
        while (pending_bytes.size() < target)
        begin
            pick = $urandom_range(0, 99);
            case (cfg_mode)
                MODE_HOST_BOUND:
                begin
                    good_magic = magic_mod;
                    odd_magic  = magic_host;
                end
                MODE_TO_MODULE:
                begin
                    good_magic = magic_host;
                    odd_magic  = magic_mod;
                end
                default:
                begin
                    good_magic = $urandom_range(0, 1) ? magic_mod : magic_host;
                    odd_magic  = 16'($urandom);
                end
            endcase
            // Pick a length the maximum accepts, if any does
            if (max_len < HDR_BYTES)
                len = 16'($urandom_range(0, HDR_BYTES - 1));
            else if (max_len <= 400 && $urandom_range(0, 19) == 0)
                len = max_len;
            else
                len = 16'($urandom_range(HDR_BYTES, (max_len < 48) ? max_len : 48));
            body = (len >= HDR_BYTES) ? len - HDR_BYTES : 0;

            if (pick < 60)
            begin
                push_frame(good_magic, 8'($urandom), 8'($urandom), len, 16'($urandom), body);
            end
            else if (pick < 72)
            begin
                if (max_len == 16'hFFFF || $urandom_range(0, 1) == 1)
                    len = 16'($urandom_range(0, HDR_BYTES - 1));
                else
                    len = max_len + 16'd1;
                push_frame(good_magic, 8'($urandom), 8'($urandom), len, 16'($urandom), 0);
            end
            else if (pick < 82)
            begin
                push_frame(odd_magic, 8'($urandom), 8'($urandom), len, 16'($urandom), body);
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom));
                // Sometimes end on a lone first half of a magic
                if ($urandom_range(0, 1) == 1)
                    pending_bytes.push_back(good_magic[7:0]);
            end
            else
            begin
                push_frame(good_magic, 8'($urandom), 8'($urandom), len, 16'($urandom), 0);
                repeat ($urandom_range(1, 7)) void'(pending_bytes.pop_back());
            end
        end
        // Often stop the phase partway through a frame
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 5)) void'(pending_bytes.pop_back());
    endfunction

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        // The register takes the value at the rising edge in between
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EXPECT_MODE: cfg_mode   = value[1:0];
            REG_MAGIC_FROM:  magic_mod  = value;
            REG_MAGIC_TO:    magic_host = value;
            REG_MAX_LEN:     max_len    = value;
            default:         ;
        endcase
    endtask

    task automatic write_all_cfg(input logic [1:0] mode, input logic [15:0] m_from,
                                 input logic [15:0] m_to, input logic [15:0] lmax);
        write_cfg(REG_EXPECT_MODE, 16'(mode));
        write_cfg(REG_MAGIC_FROM, m_from);
        write_cfg(REG_MAGIC_TO, m_to);
        write_cfg(REG_MAX_LEN, lmax);
    endtask

    // Hold until every byte is taken and every predicted beat has come out.
    // Sample at the rising edge, where the driver never changes in_valid.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Input driver: bursts of random length with random gaps, changes at the
    // falling edge, holds a beat until it is taken
    // ------------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge clk)
    begin : drive_in
        logic  next_valid;
        byte_t next_byte;
        next_valid = 1'b0;
        next_byte  = data_byte;
        if (rst_n)
        begin
            if (!(in_valid && !in_fire))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_valid = 1'b1;
                    next_byte  = pending_bytes.pop_front();
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 8);
                    end
                end
                in_valid  <= next_valid;
                data_byte <= next_byte;
            end
            in_fire = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output stalls: a 16-bit ready pattern played in a loop and redrawn
    // periodically; a quarter of the patterns never stall
    // ------------------------------------------------------------------------
    logic [15:0] ready_pat  = 16'hFFFF;
    int unsigned stall_tick = 0;

    always @(negedge clk)
    begin
        if (stall_tick % 64 == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                ready_pat = 16'hFFFF;
            else
                ready_pat = 16'($urandom) | (16'h0001 << $urandom_range(0, 15));
        end
        out_ready <= ready_pat[stall_tick % 16];
        stall_tick++;
    end

    // ------------------------------------------------------------------------
    // Monitor: check result beats, predict accepted input beats, watchdog
    // ------------------------------------------------------------------------
    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : watch_out
        res_t want;
        if (rst_n)
        begin
            // Check before predicting: a result never belongs to the byte
            // taken at the same edge
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result beat expected none, got kind 0x%0h", $time, kind);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    cmp_field("kind", 32'(want.frame.kind), 32'(kind));
                    cmp_field("host_bound", 32'(want.frame.host_bound), 32'(host_bound));
                    cmp_field("frame_type", 32'(want.frame.frame_type), 32'(frame_type));
                    cmp_field("if_index", 32'(want.frame.if_index), 32'(if_index));
                    cmp_field("frame_flags", 32'(want.frame.frame_flags), 32'(frame_flags));
                    cmp_field("frame_length", 32'(want.frame.frame_length), 32'(frame_length));
                    cmp_field("frame_cookie", 32'(want.frame.frame_cookie), 32'(frame_cookie));
                    cmp_field("payload_byte", 32'(want.frame.payload_byte), 32'(payload_byte));
                    cmp_field("last", 32'(want.frame.last), 32'(last));
                    cmp_field("garbage_total", want.garbage_total, garbage_total);
                    cmp_field("bad_length_total", want.bad_length_total, bad_length_total);
                end
            end
            if (in_valid && in_ready)
            begin
                deframe_byte(data_byte);
                in_fire = 1'b1;
            end
            if ((out_valid && out_ready) || (in_valid && in_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [1:0]  mode;
        logic [15:0] m_from;
        logic [15:0] m_to;
        logic [15:0] lmax;

        // Reset settings: both magics zero, so every header counts as from
        // the module. Lead with a garbage byte, then a header-only frame with
        // all-ones type and cookie, then a length below the header size.
        pending_bytes.push_back(8'hFF);
        push_frame(16'h0000, 8'hFF, 8'hA5, 16'd8, 16'hFFFF, 0);
        push_frame(16'h0000, 8'h00, 8'h0F, 16'd7, 16'h1234, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_idle();
        // Module-to-host only: a host-to-module header is garbage, a length
        // one above the maximum is rejected, then a frame stopped mid-payload
        write_all_cfg(MODE_HOST_BOUND, 16'hA55A, 16'h3CC3, 16'd12);
        push_frame(16'h3CC3, 8'h01, 8'h00, 16'd8, 16'h0000, 0);
        push_frame(16'hA55A, 8'h02, 8'hF0, 16'd13, 16'h0000, 0);
        push_frame(16'hA55A, 8'h80, 8'h5A, 16'd12, 16'h8001, 0);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);

        wait_idle();
        // Change settings mid-frame: the open frame keeps its length
        write_cfg(REG_MAX_LEN, 16'd8);
        write_cfg(REG_EXPECT_MODE, 16'(MODE_TO_MODULE));
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'hAA);
        push_frame(16'h3CC3, 8'h7F, 8'hC3, 16'd8, 16'hFFFF, 0);
        push_frame(16'hA55A, 8'h7F, 8'hC3, 16'd8, 16'hFFFF, 0);

        // Random phases, each with fresh settings that sweep the extremes
        for (int ph = 0; ph < 10; ph++)
        begin
            wait_idle();
            mode = 2'(ph % 4);
            case (ph % 5)
                0:
                begin
                    m_from = 16'($urandom);
                    m_to   = 16'($urandom);
                end
                1:
                begin
                    m_from = 16'($urandom);
                    m_to   = m_from;
                end
                2:
                begin
                    m_from = 16'h0000;
                    m_to   = 16'hFFFF;
                end
                3:
                begin
                    m_from = 16'hFFFF;
                    m_to   = 16'h0000;
                end
                default:
                begin
                    m_from = 16'($urandom);
                    m_to   = {m_from[7:0], m_from[15:8]};
                end
            endcase
            case (ph)
                0:       lmax = 16'd0;
                1:       lmax = 16'd8;
                2:       lmax = 16'hFFFF;
                3:       lmax = 16'd7;
                4:       lmax = 16'd2048;
                5:       lmax = 16'd9;
                6:       lmax = 16'd300;
                7:       lmax = 16'd24;
                8:       lmax = 16'($urandom_range(8, 64));
                default: lmax = 16'd40;
            endcase
            write_all_cfg(mode, m_from, m_to, lmax);
            build_phase(PHASE_BYTES);
        end

        wait_idle();
        // Allow the output register and skid stage to settle
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
